// ----- hw/rtl/sce_pkg.sv -----
// Shared types and constants for the seam cumulative energy block.
// Used by sce_cost_calc, seam_cumulative_energy, sce_checker and tb_top; depends on nothing.
package sce_pkg;

    localparam int ENERGY_W  = 15;
    localparam int SUM_W     = 31;
    localparam int CFG_LEN_W = 11;
    localparam int PADDR_W   = 3;
    localparam int PDATA_W   = 32;

    localparam logic [CFG_LEN_W-1:0] LINE_LENGTH_RESET = 11'd1024;
    localparam logic [SUM_W-1:0]     SUM_MAX           = 31'h7FFF_FFFF;

    // Register index taken from the word address.
    localparam logic REG_LINE_LENGTH = 1'b0;

    typedef struct packed {
        logic [ENERGY_W-1:0] energy_value;
        logic                frame_start;
    } sce_in_t;

    typedef struct packed {
        logic [SUM_W-1:0] cumulative_energy;
        logic             saturated;
    } sce_out_t;

    // Neighbourhood of one pixel as seen by the cost calculation.
    typedef struct packed {
        logic [ENERGY_W-1:0] energy;
        logic [SUM_W-1:0]    up;
        logic [SUM_W-1:0]    left;
        logic [SUM_W-1:0]    right;
        logic                col_zero;
        logic                last;
        logic                first_line;
    } sce_win_t;

endpackage

// ----- hw/rtl/sce_cost_calc.sv -----
// Cumulative cost of one pixel: own energy plus the least valid neighbour above,
// saturated at the 31-bit maximum; on the first line, the energy alone. Depends on sce_pkg.
module sce_cost_calc (
    input  sce_pkg::sce_win_t               win,
    output logic [sce_pkg::SUM_W-1:0]       result,
    output logic                            sat
);

    logic [sce_pkg::SUM_W-1:0] best_a;
    logic [sce_pkg::SUM_W-1:0] best_b;
    logic [sce_pkg::SUM_W:0]   sum;

    always_comb begin
        best_a = (!win.col_zero && (win.left < win.up)) ? win.left : win.up;
        best_b = (!win.last && (win.right < best_a)) ? win.right : best_a;
        sum    = {1'b0, best_b} + (sce_pkg::SUM_W + 1)'(win.energy);
        if (win.first_line) begin
            result = sce_pkg::SUM_W'(win.energy);
            sat    = 1'b0;
        end else begin
            sat    = sum[sce_pkg::SUM_W];
            result = sat ? sce_pkg::SUM_MAX : sum[sce_pkg::SUM_W-1:0];
        end
    end

endmodule

// ----- hw/rtl/seam_cumulative_energy.sv -----
// Seam carving cumulative energy map: top level with line store and APB register.
// Depends on sce_pkg and sce_cost_calc.
// An accepted pixel waits in stage s1 for the output register. Throughput: one pixel per
// cycle unless m_ready stalls, set by the single write and two reads of the line store.
// Reset: control state, the column count and the line length register are restored; the
// line store is not cleared, and the block accepts transactions from the first cycle.
module seam_cumulative_energy #(
    parameter int MAX_LINE = 1024
) (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              s_valid,
    output logic                              s_ready,
    input  sce_pkg::sce_in_t                  s_data,
    output logic                              m_valid,
    input  logic                              m_ready,
    output sce_pkg::sce_out_t                 m_data,
    input  logic                              psel,
    input  logic                              penable,
    input  logic                              pwrite,
    input  logic [sce_pkg::PADDR_W-1:0]       paddr,
    input  logic [sce_pkg::PDATA_W-1:0]       pwdata,
    output logic [sce_pkg::PDATA_W-1:0]       prdata,
    output logic                              pready
);

    localparam int CW    = (MAX_LINE > 1) ? $clog2(MAX_LINE) : 1;
    localparam int LEN_W = ((CW + 1) > sce_pkg::CFG_LEN_W) ? (CW + 1) : sce_pkg::CFG_LEN_W;
    localparam logic [LEN_W-1:0] MAX_LEN = LEN_W'(MAX_LINE);
    localparam logic [LEN_W-1:0] ONE_LEN = LEN_W'(1);

    logic [sce_pkg::CFG_LEN_W-1:0] line_length_reg;
    logic                          cfg_write;

    logic [CW-1:0]                 column_count_reg;
    logic [CW-1:0]                 column_count_next;
    logic                          first_line_reg;
    logic                          first_line_next;

    logic                          s1_valid_reg;
    logic [sce_pkg::ENERGY_W-1:0]  s1_energy_reg;
    logic [CW-1:0]                 s1_col_reg;
    logic                          s1_first_reg;
    logic                          s1_last_reg;
    logic                          hit0_reg;
    logic                          hit1_reg;
    logic [sce_pkg::SUM_W-1:0]     rd0_reg;
    logic [sce_pkg::SUM_W-1:0]     rd1_reg;
    logic [sce_pkg::SUM_W-1:0]     last_wr_reg;
    logic [sce_pkg::SUM_W-1:0]     left_reg;

    logic                          m_valid_reg;
    sce_pkg::sce_out_t             m_data_reg;

    logic                          accept;
    logic                          s1_adv;
    logic [CW-1:0]                 col;
    logic [CW-1:0]                 col_p1;
    logic                          fl;
    logic                          last;
    logic [LEN_W-1:0]              len_ext;
    logic [LEN_W-1:0]              len_eff;
    logic [LEN_W-1:0]              col_p1_ext;

    logic [sce_pkg::SUM_W-1:0]     line_mem [MAX_LINE];

    sce_pkg::sce_win_t             win;
    logic [sce_pkg::SUM_W-1:0]     result;
    logic                          sat;

    // Configuration port.
    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite
                       && (paddr[2] == sce_pkg::REG_LINE_LENGTH);

    always_comb begin
        prdata = '0;
        if (paddr[2] == sce_pkg::REG_LINE_LENGTH) begin
            prdata = sce_pkg::PDATA_W'(line_length_reg);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            line_length_reg <= sce_pkg::LINE_LENGTH_RESET;
        end else if (cfg_write) begin
            line_length_reg <= pwdata[sce_pkg::CFG_LEN_W-1:0];
        end
    end

    // Handshake.
    assign s1_adv  = s1_valid_reg && (!m_valid_reg || m_ready);
    assign s_ready = !s1_valid_reg || s1_adv;
    assign accept  = s_valid && s_ready;
    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

    // Column tracking at acceptance.
    always_comb begin
        col        = s_data.frame_start ? '0 : column_count_reg;
        fl         = s_data.frame_start || first_line_reg;
        col_p1     = col + CW'(1);
        len_ext    = LEN_W'(line_length_reg);
        if (len_ext == '0) begin
            len_eff = ONE_LEN;
        end else if (len_ext > MAX_LEN) begin
            len_eff = MAX_LEN;
        end else begin
            len_eff = len_ext;
        end
        col_p1_ext = LEN_W'(col) + ONE_LEN;
        last       = (col_p1_ext >= len_eff);
        column_count_next = last ? '0 : col_p1;
        first_line_next   = last ? 1'b0 : fl;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            column_count_reg <= '0;
            first_line_reg   <= 1'b1;
            s1_valid_reg     <= 1'b0;
            m_valid_reg      <= 1'b0;
            left_reg         <= '0;
            hit0_reg         <= 1'b0;
            hit1_reg         <= 1'b0;
        end else begin
            if (accept) begin
                column_count_reg <= column_count_next;
                first_line_reg   <= first_line_next;
                s1_valid_reg     <= 1'b1;
                hit0_reg         <= s1_adv && (s1_col_reg == col);
                hit1_reg         <= s1_adv && (s1_col_reg == col_p1);
            end else if (s1_adv) begin
                s1_valid_reg     <= 1'b0;
            end
            if (s1_adv) begin
                m_valid_reg <= 1'b1;
                left_reg    <= win.up;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            s1_energy_reg <= s_data.energy_value;
            s1_col_reg    <= col;
            s1_first_reg  <= fl;
            s1_last_reg   <= last;
        end
        if (s1_adv) begin
            m_data_reg.cumulative_energy <= result;
            m_data_reg.saturated         <= sat;
            last_wr_reg                  <= result;
        end
    end

    // Line store: one write and two registered reads per cycle.
    always_ff @(posedge aclk) begin
        if (s1_adv) begin
            line_mem[s1_col_reg] <= result;
        end
        if (accept) begin
            rd0_reg <= line_mem[col];
            rd1_reg <= line_mem[col_p1];
        end
    end

    always_comb begin
        win.energy     = s1_energy_reg;
        win.up         = hit0_reg ? last_wr_reg : rd0_reg;
        win.right      = hit1_reg ? last_wr_reg : rd1_reg;
        win.left       = left_reg;
        win.col_zero   = (s1_col_reg == '0);
        win.last       = s1_last_reg;
        win.first_line = s1_first_reg;
    end

    sce_cost_calc u_cost_calc (
        .win    (win),
        .result (result),
        .sat    (sat)
    );

endmodule

// ----- sim/sce_checker.sv -----
// Checker for the seam cumulative energy block: watches the pixel, result and register
// ports, predicts the cost of every accepted pixel and compares it with the result stream.
// Depends on sce_pkg.
module sce_checker #(
    parameter int MAX_LINE = 1024
) (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        s_valid,
    input  logic                        s_ready,
    input  sce_pkg::sce_in_t            s_data,
    input  logic                        m_valid,
    input  logic                        m_ready,
    input  sce_pkg::sce_out_t           m_data,
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [sce_pkg::PADDR_W-1:0] paddr,
    input  logic [sce_pkg::PDATA_W-1:0] pwdata,
    input  logic [sce_pkg::PDATA_W-1:0] prdata,
    input  logic                        pready,
    output int                          errors,
    output int                          pending
);

    bit [sce_pkg::SUM_W-1:0]       prev_line [MAX_LINE];
    int unsigned                   column;
    bit                            in_first_line;
    bit [sce_pkg::SUM_W-1:0]       above_left;
    bit [sce_pkg::SUM_W-1:0]       above_next;
    logic [sce_pkg::CFG_LEN_W-1:0] line_len;
    sce_pkg::sce_out_t             pending_costs [$];
    sce_pkg::sce_out_t             want;
    int                            fails = 0;
    int                            waiting = 0;

    assign errors  = fails;
    assign pending = waiting;

    function automatic sce_pkg::sce_out_t next_cost(input sce_pkg::sce_in_t px);
        sce_pkg::sce_out_t       r;
        int unsigned             len;
        int unsigned             c;
        bit                      last;
        bit [sce_pkg::SUM_W-1:0] up;
        bit [sce_pkg::SUM_W-1:0] best;
        bit [sce_pkg::SUM_W-1:0] right;
        bit [sce_pkg::SUM_W:0]   sum;
        len = line_len;
        if (len == 0) len = 1;
        if (len > MAX_LINE) len = MAX_LINE;
        if (px.frame_start) begin
            column = 0;
            in_first_line = 1'b1;
        end
        c = column;
        last = (c + 1 >= len);
        r.saturated = 1'b0;
        if (in_first_line) begin
            r.cumulative_energy = sce_pkg::SUM_W'(px.energy_value);
            above_left = '0;
            above_next = '0;
        end else begin
            up = (c == 0) ? prev_line[0] : above_next;
            best = up;
            right = '0;
            if (c != 0 && above_left < best) best = above_left;
            if (!last) begin
                right = (c + 1 < MAX_LINE) ? prev_line[c + 1] : '0;
                if (right < best) best = right;
            end
            sum = {1'b0, best} + (sce_pkg::SUM_W + 1)'(px.energy_value);
            if (sum > {1'b0, sce_pkg::SUM_MAX}) begin
                sum = {1'b0, sce_pkg::SUM_MAX};
                r.saturated = 1'b1;
            end
            r.cumulative_energy = sum[sce_pkg::SUM_W-1:0];
            above_left = up;
            above_next = right;
        end
        if (c < MAX_LINE) prev_line[c] = r.cumulative_energy;
        if (last) begin
            column = 0;
            in_first_line = 1'b0;
        end else begin
            column = c + 1;
        end
        return r;
    endfunction

    always @(posedge aclk) begin
        if (!aresetn) begin
            column = 0;
            in_first_line = 1'b1;
            above_left = '0;
            above_next = '0;
            line_len = sce_pkg::LINE_LENGTH_RESET;
            pending_costs.delete();
        end else begin
            if (s_valid && s_ready) pending_costs.push_back(next_cost(s_data));
            if (m_valid && m_ready) begin
                if (pending_costs.size() == 0) begin
                    $display("%0t: unexpected result: got %0d sat %0b", $time,
                             m_data.cumulative_energy, m_data.saturated);
                    fails++;
                end else begin
                    want = pending_costs.pop_front();
                    if (m_data.cumulative_energy !== want.cumulative_energy ||
                            m_data.saturated !== want.saturated) begin
                        $display("%0t: result mismatch: expected %0d sat %0b, got %0d sat %0b",
                                 $time, want.cumulative_energy, want.saturated,
                                 m_data.cumulative_energy, m_data.saturated);
                        fails++;
                    end
                end
            end
            if (psel && penable && pready
                    && paddr[sce_pkg::PADDR_W-1] == sce_pkg::REG_LINE_LENGTH) begin
                if (pwrite) begin
                    line_len = pwdata[sce_pkg::CFG_LEN_W-1:0];
                end else if (prdata !== sce_pkg::PDATA_W'(line_len)) begin
                    $display("%0t: line length readback: expected %0d, got %0d", $time,
                             line_len, prdata);
                    fails++;
                end
            end
        end
        waiting = pending_costs.size();
    end

endmodule

// ----- sim/tb_top.sv -----
// Top level of the seam cumulative energy testbench: clock, reset, pixel and register
// stimulus, result back-pressure and the verdict. Depends on sce_pkg, sce_checker and
// seam_cumulative_energy.
module tb_top;

    localparam int MAX_LINE    = 1024;
    localparam int STALL_LIMIT = 5000;
    localparam int N_PHASES    = 12;
    localparam int unsigned E_MAX = (1 << sce_pkg::ENERGY_W) - 1;
    localparam logic [sce_pkg::PADDR_W-1:0] LEN_ADDR = {sce_pkg::REG_LINE_LENGTH, 2'b00};

    logic                        aclk = 1'b0;
    logic                        aresetn;
    logic                        s_valid;
    logic                        s_ready;
    sce_pkg::sce_in_t            s_data;
    logic                        m_valid;
    logic                        m_ready = 1'b0;
    sce_pkg::sce_out_t           m_data;
    logic                        psel;
    logic                        penable;
    logic                        pwrite;
    logic [sce_pkg::PADDR_W-1:0] paddr;
    logic [sce_pkg::PDATA_W-1:0] pwdata;
    logic [sce_pkg::PDATA_W-1:0] prdata;
    logic                        pready;

    int          errors;
    int          pending;
    int          send_idle_pct = 0;
    int          stall_pct = 0;
    int          quiet_cycles = 0;
    int unsigned cur_len;
    bit          force_frame;

    seam_cumulative_energy #(.MAX_LINE(MAX_LINE)) u_top (
        .aclk(aclk), .aresetn(aresetn),
        .s_valid(s_valid), .s_ready(s_ready), .s_data(s_data),
        .m_valid(m_valid), .m_ready(m_ready), .m_data(m_data),
        .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
        .pwdata(pwdata), .prdata(prdata), .pready(pready)
    );

    sce_checker #(.MAX_LINE(MAX_LINE)) u_checker (
        .aclk(aclk), .aresetn(aresetn),
        .s_valid(s_valid), .s_ready(s_ready), .s_data(s_data),
        .m_valid(m_valid), .m_ready(m_ready), .m_data(m_data),
        .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
        .pwdata(pwdata), .prdata(prdata), .pready(pready),
        .errors(errors), .pending(pending)
    );

    always #10 aclk = ~aclk;

    always @(negedge aclk) begin
        m_ready <= ($urandom_range(99) >= stall_pct);
    end

    always @(posedge aclk) begin
        if ((s_valid && s_ready) || (m_valid && m_ready) || psel)
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= STALL_LIMIT) begin
            $display("DONE: errors detected");
            $finish;
        end
    end

    function automatic int unsigned active_length(input int unsigned v);
        if (v == 0) return 1;
        if (v > MAX_LINE) return MAX_LINE;
        return v;
    endfunction

    function automatic int unsigned phase_length(input int p);
        case (p)
            0:       return 2;
            1:       return 7;
            2:       return 16;
            3:       return 1;
            4:       return 5;
            5:       return 64;
            6:       return 3;
            7:       return 1024;
            8:       return 33;
            9:       return 2;
            10:      return 11;
            default: return 4;
        endcase
    endfunction

    function automatic sce_pkg::sce_in_t rand_pixel();
        sce_pkg::sce_in_t px;
        case ($urandom_range(9))
            0:       px.energy_value = '0;
            1:       px.energy_value = '1;
            2, 3:    px.energy_value = sce_pkg::ENERGY_W'($urandom_range(63));
            default: px.energy_value = sce_pkg::ENERGY_W'($urandom_range(E_MAX));
        endcase
        px.frame_start = ($urandom_range(49) == 0);
        return px;
    endfunction

    task automatic set_idling(input int mode);
        case (mode)
            0: begin
                send_idle_pct = 0;
                stall_pct = 0;
            end
            1: begin
                send_idle_pct = 52;
                stall_pct = 0;
            end
            2: begin
                send_idle_pct = 0;
                stall_pct = 52;
            end
            default: begin
                send_idle_pct = 15;
                stall_pct = 15;
            end
        endcase
    endtask

    task automatic push_pixel(input sce_pkg::sce_in_t px);
        while ($urandom_range(99) < send_idle_pct) begin
            s_valid <= 1'b0;
            @(negedge aclk);
        end
        if (force_frame) begin
            px.frame_start = 1'b1;
            force_frame = 1'b0;
        end
        s_valid <= 1'b1;
        s_data <= px;
        @(posedge aclk);
        while (s_ready !== 1'b1) @(posedge aclk);
        @(negedge aclk);
    endtask

    task automatic push_energy(input int unsigned e, input bit fs);
        sce_pkg::sce_in_t px;
        px.energy_value = e[sce_pkg::ENERGY_W-1:0];
        px.frame_start = fs;
        push_pixel(px);
    endtask

    task automatic drain();
        s_valid <= 1'b0;
        while (pending != 0) @(negedge aclk);
        repeat (4) @(negedge aclk);
    endtask

    // A longer line would read store entries that the previous line never wrote,
    // so any growth starts a fresh frame.
    task automatic set_length(input int unsigned v);
        drain();
        if (active_length(v) > cur_len) force_frame = 1'b1;
        cur_len = active_length(v);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= LEN_ADDR;
        pwdata <= sce_pkg::PDATA_W'(v);
        @(negedge aclk);
        penable <= 1'b1;
        @(negedge aclk);
        penable <= 1'b0;
        pwrite <= 1'b0;
        @(negedge aclk);
        penable <= 1'b1;
        @(negedge aclk);
        psel <= 1'b0;
        penable <= 1'b0;
    endtask

    initial begin
        int count;
        aresetn = 1'b0;
        s_valid = 1'b0;
        s_data = '0;
        psel = 1'b0;
        penable = 1'b0;
        pwrite = 1'b0;
        paddr = '0;
        pwdata = '0;
        force_frame = 1'b0;
        cur_len = active_length(sce_pkg::LINE_LENGTH_RESET);
        set_idling(0);
        repeat (10) @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        // No frame start after reset, then shorter lengths that end a line mid-line, zero and above the maximum.
        push_energy(0, 1'b0);
        push_energy(E_MAX, 1'b0);
        push_energy(32'h5555, 1'b0);
        push_energy(32'h2AAA, 1'b0);
        set_length(3);
        push_energy(100, 1'b0);
        push_energy(10, 1'b0);
        push_energy(20, 1'b0);
        push_energy(30, 1'b0);
        push_energy(E_MAX, 1'b0);
        push_energy(0, 1'b0);
        push_energy(5, 1'b0);
        set_length(1);
        push_energy(7, 1'b0);
        push_energy(E_MAX, 1'b0);
        push_energy(0, 1'b0);
        set_length(0);
        push_energy(1, 1'b0);
        push_energy(2, 1'b0);
        set_length(2047);
        push_energy(3, 1'b0);
        push_energy(4, 1'b0);

        // Single-pixel lines, first at full energy, then small and random energies, each one adding to the one above.
        set_length(0);
        push_energy(E_MAX, 1'b1);
        repeat (12) push_energy(E_MAX, 1'b0);
        push_energy(1, 1'b0);
        push_energy(1, 1'b0);
        push_energy(0, 1'b0);
        push_energy(E_MAX, 1'b0);
        repeat (8) push_pixel(rand_pixel());

        for (int p = 0; p < N_PHASES; p++) begin
            set_idling(p % 4);
            set_length(phase_length(p));
            count = (phase_length(p) == MAX_LINE) ? MAX_LINE + 6 : 12 + int'(phase_length(p));
            repeat (count) push_pixel(rand_pixel());
        end

        drain();
        repeat (6) @(negedge aclk);
        if (errors == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

endmodule

// ----- filelist.f -----
hw/rtl/sce_pkg.sv
hw/rtl/sce_cost_calc.sv
hw/rtl/seam_cumulative_energy.sv
sim/sce_checker.sv
sim/tb_top.sv
